>>> rtl/pmd_pkg.sv
// Shared types and constants for the dense Prim spanning tree block.
// No dependencies; imported by pmd_seq and prim_mst_dense.
package pmd_pkg;

	localparam int PMD_MAX_VERTICES = 32;
	localparam int PMD_WEIGHT_BITS  = 16;

	// Field widths on the stream and config ports
	localparam int CMD_W    = 1;
	localparam int IDX_W    = 5;
	localparam int WGT_W    = 16;
	localparam int TOTAL_W  = 21;
	localparam int CFG_W    = 6;
	localparam int S_DATA_W = 32;
	localparam int M_DATA_W = 48;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_WRITE = 1'b0;
	localparam logic [CMD_W-1:0] CMD_RUN   = 1'b1;

	localparam logic [CFG_W-1:0] VC_RESET = 6'd25;

	// One result of a run
	typedef struct packed {
		logic [IDX_W-1:0]   vertex;
		logic [IDX_W-1:0]   parent_vertex;
		logic [WGT_W-1:0]   edge_weight;
		logic               reachable;
		logic [TOTAL_W-1:0] total_cost;
		logic               last;
	} pmd_res_t;

endpackage

>>> rtl/prim_mst_dense.sv
// Top level of the dense Prim minimum spanning tree block.
// Depends on pmd_pkg, pmd_seq and pmd_ram.
//
// Usage:
//   Slave stream s_*: tuser selects the command. A write transfer
//   (CMD_WRITE) stores one directed matrix entry; weight 0 means no edge.
//   A run transfer (CMD_RUN) builds a tree from vertex 0 over the first
//   vertex_count vertices (clamped to 2..MAX_VERTICES).
//   Master stream m_*: one transfer per vertex 1..n-1 in ascending order,
//   tlast on vertex n-1. tuser flags whether the vertex was reached.
//   cfg_we/cfg_wdata write vertex_count; write it only while idle.
// Timing:
//   After reset the matrix RAM is cleared one entry a cycle, over all
//   2^(2*ceil(log2(MAX_VERTICES))) entries (1024 by default); s_tready is low.
//   Writes stream back to back. A run initialises the vertex RAM, then
//   makes scan/relax passes, each reading the vertex RAM once per vertex,
//   then steps each result through the ORDV, ORDA and OEMIT states.
//   A stalled receiver holds the result in the output register and the
//   sequencer waits; s_tready returns once the last result is loaded.
module prim_mst_dense #(
	parameter int MAX_VERTICES = pmd_pkg::PMD_MAX_VERTICES,
	parameter int WEIGHT_BITS  = pmd_pkg::PMD_WEIGHT_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// row [4:0], col [9:5], weight [25:10], zero fill above
	input  logic [pmd_pkg::S_DATA_W-1:0]   s_tdata,
	// command [0]
	input  logic [pmd_pkg::CMD_W-1:0]      s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// vertex [4:0], parent_vertex [9:5], edge_weight [25:10],
	// total_cost [46:26], zero [47]
	output logic [pmd_pkg::M_DATA_W-1:0]   m_tdata,
	// reachable [0]
	output logic                           m_tuser,
	output logic                           m_tlast,
	input  logic                           cfg_we,
	input  logic [pmd_pkg::CFG_W-1:0]      cfg_wdata
);
	import pmd_pkg::*;

	localparam int NW = $clog2(MAX_VERTICES + 1);

	logic [CFG_W-1:0] vc_q;
	logic [NW-1:0]    n_used;
	pmd_res_t         res;

	// Hold vertex_count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q <= VC_RESET;
		end else if (cfg_we) begin
			vc_q <= cfg_wdata;
		end
	end

	// Clamp vertex count into 2..MAX_VERTICES
	always_comb begin
		if (vc_q < CFG_W'(2)) begin
			n_used = NW'(2);
		end else if (int'(vc_q) > MAX_VERTICES) begin
			n_used = NW'(MAX_VERTICES);
		end else begin
			n_used = NW'(vc_q);
		end
	end

	pmd_seq #(.MAX_VERTICES(MAX_VERTICES), .WEIGHT_BITS(WEIGHT_BITS)) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_cmd    (s_tuser),
		.in_row    (s_tdata[IDX_W-1:0]),
		.in_col    (s_tdata[2*IDX_W-1:IDX_W]),
		.in_weight (s_tdata[2*IDX_W+WGT_W-1:2*IDX_W]),
		.n_used    (n_used),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	// Pack the result transfer
	assign m_tdata = {1'b0, res.total_cost, res.edge_weight, res.parent_vertex, res.vertex};
	assign m_tuser = res.reachable;
	assign m_tlast = res.last;

	// A run holds off further input
	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == CMD_RUN) |=> !s_tready)
		else $error("input taken right after a run transfer");

	// Writes stream one per cycle
	a_write_stream: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == CMD_WRITE) |=> s_tready)
		else $error("ready dropped after a write transfer");

	// Mid-run results imply the block is still busy
	a_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("ready while a run still has results pending");

endmodule

>>> rtl/pmd_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies; holds the adjacency matrix and the per-vertex state.
module pmd_ram #(
	parameter int ADDR_BITS = 5,
	parameter int DATA_BITS = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] waddr,
	input  logic [DATA_BITS-1:0] wdata,
	input  logic                 re,
	input  logic [ADDR_BITS-1:0] raddr,
	output logic [DATA_BITS-1:0] rdata
);

	logic [DATA_BITS-1:0] mem [1<<ADDR_BITS];
	logic [DATA_BITS-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/pmd_seq.sv
// Sequencer for the dense Prim method: clears and writes the adjacency RAM,
// runs scan/relax passes over the vertex RAM and emits results. Uses pmd_pkg, pmd_ram.
module pmd_seq #(
	parameter int MAX_VERTICES = pmd_pkg::PMD_MAX_VERTICES,
	parameter int WEIGHT_BITS  = pmd_pkg::PMD_WEIGHT_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [pmd_pkg::CMD_W-1:0]            in_cmd,
	input  logic [pmd_pkg::IDX_W-1:0]            in_row,
	input  logic [pmd_pkg::IDX_W-1:0]            in_col,
	input  logic [pmd_pkg::WGT_W-1:0]            in_weight,
	input  logic [$clog2(MAX_VERTICES+1)-1:0]    n_used,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output pmd_pkg::pmd_res_t                    out_res
);
	import pmd_pkg::*;

	localparam int VB = $clog2(MAX_VERTICES);
	localparam int AB = 2 * VB;
	localparam int NW = $clog2(MAX_VERTICES + 1);
	localparam int KW = WEIGHT_BITS + 1;
	localparam int EW = 1 + VB + KW;
	localparam int TW = WEIGHT_BITS + VB;
	localparam logic [KW-1:0] KEY_INF = {1'b1, {WEIGHT_BITS{1'b0}}};

	localparam logic [3:0] ST_CLR   = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_INIT  = 4'd2;
	localparam logic [3:0] ST_SCAN  = 4'd3;
	localparam logic [3:0] ST_RELAX = 4'd4;
	localparam logic [3:0] ST_ORDV  = 4'd5;
	localparam logic [3:0] ST_ORDA  = 4'd6;
	localparam logic [3:0] ST_OEMIT = 4'd7;

	logic [3:0]          state_q;
	logic [AB-1:0]       clr_q;
	logic [NW-1:0]       cnt_q, n_q, left_q;
	logic                rd_v_s1;
	logic [VB-1:0]       idx_s1;
	logic [KW-1:0]       lowest_q;
	logic [VB-1:0]       pick_q, oi_q, opar_q;
	logic                found_q, oreach_q;
	logic [TW-1:0]       total_q;
	logic                out_valid_q;
	pmd_res_t            res_q;

	logic                adj_we, adj_re, vtx_we, vtx_re;
	logic [AB-1:0]       adj_waddr, adj_raddr;
	logic [WEIGHT_BITS-1:0] adj_wdata, adj_rdata;
	logic [VB-1:0]       vtx_waddr, vtx_raddr;
	logic [EW-1:0]       vtx_wdata, vtx_rdata;

	logic                accept, row_ok, issue, pass, drained;
	logic                e_in, in_new, upd, better, load, is_last;
	logic [VB-1:0]       e_par;
	logic [KW-1:0]       e_key;
	logic [WEIGHT_BITS-1:0] ew_add;

	pmd_ram #(.ADDR_BITS(AB), .DATA_BITS(WEIGHT_BITS)) u_adj (
		.clk(clk), .we(adj_we), .waddr(adj_waddr), .wdata(adj_wdata),
		.re(adj_re), .raddr(adj_raddr), .rdata(adj_rdata)
	);

	pmd_ram #(.ADDR_BITS(VB), .DATA_BITS(EW)) u_vtx (
		.clk(clk), .we(vtx_we), .waddr(vtx_waddr), .wdata(vtx_wdata),
		.re(vtx_re), .raddr(vtx_raddr), .rdata(vtx_rdata)
	);

	// Decode vertex entry and handshakes
	assign e_in     = vtx_rdata[EW-1];
	assign e_par    = vtx_rdata[KW +: VB];
	assign e_key    = vtx_rdata[KW-1:0];
	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign row_ok   = (int'(in_row) < MAX_VERTICES) && (int'(in_col) < MAX_VERTICES);
	assign pass     = (state_q == ST_SCAN) || (state_q == ST_RELAX);
	assign issue    = pass && (cnt_q < n_q);
	assign drained  = !issue && !rd_v_s1;

	// Scan compare and relax update
	assign better = !e_in && (e_key < lowest_q);
	assign in_new = e_in || (idx_s1 == pick_q);
	assign upd    = (adj_rdata != '0) && !in_new && ({1'b0, adj_rdata} < e_key);

	// Result load into the output register
	assign load    = (state_q == ST_OEMIT) && (!out_valid_q || out_ready);
	assign is_last = ((NW'(oi_q) + NW'(1)) == n_q);
	assign ew_add  = oreach_q ? adj_rdata : '0;

	// Adjacency RAM access
	always_comb begin
		adj_we    = 1'b0;
		adj_waddr = {VB'(in_row), VB'(in_col)};
		adj_wdata = WEIGHT_BITS'(in_weight);
		adj_re    = 1'b0;
		adj_raddr = {pick_q, cnt_q[VB-1:0]};
		if (state_q == ST_CLR) begin
			adj_we    = 1'b1;
			adj_waddr = clr_q;
			adj_wdata = '0;
		end else begin
			adj_we = accept && (in_cmd == CMD_WRITE) && row_ok;
		end
		if (state_q == ST_RELAX) begin
			adj_re = issue;
		end else if (state_q == ST_ORDA) begin
			adj_re    = 1'b1;
			adj_raddr = {oi_q, e_par};
		end
	end

	// Vertex RAM access
	always_comb begin
		vtx_re    = issue;
		vtx_raddr = cnt_q[VB-1:0];
		vtx_we    = 1'b0;
		vtx_waddr = cnt_q[VB-1:0];
		vtx_wdata = {1'b0, {VB{1'b0}}, (cnt_q == '0) ? {KW{1'b0}} : KEY_INF};
		if (state_q == ST_ORDV) begin
			vtx_re    = 1'b1;
			vtx_raddr = oi_q;
		end
		if (state_q == ST_INIT) begin
			vtx_we = (cnt_q < n_q);
		end else if ((state_q == ST_RELAX) && rd_v_s1) begin
			vtx_we    = 1'b1;
			vtx_waddr = idx_s1;
			vtx_wdata = {in_new, upd ? pick_q : e_par,
				upd ? {1'b0, adj_rdata} : e_key};
		end
	end

	// Read pipeline tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[VB-1:0];
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLR;
			clr_q    <= '0;
			cnt_q    <= '0;
			n_q      <= NW'(2);
			left_q   <= '0;
			lowest_q <= KEY_INF;
			pick_q   <= '0;
			found_q  <= 1'b0;
			oi_q     <= '0;
			opar_q   <= '0;
			oreach_q <= 1'b0;
			total_q  <= '0;
		end else begin
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + AB'(1);
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && (in_cmd == CMD_RUN)) begin
						n_q     <= n_used;
						cnt_q   <= '0;
						state_q <= ST_INIT;
					end
				end
				ST_INIT: begin
					if (cnt_q < n_q) begin
						cnt_q <= cnt_q + NW'(1);
					end else begin
						cnt_q    <= '0;
						left_q   <= n_q - NW'(1);
						lowest_q <= KEY_INF;
						found_q  <= 1'b0;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN, ST_RELAX: begin
					if (issue) begin
						cnt_q <= cnt_q + NW'(1);
					end
					if ((state_q == ST_SCAN) && rd_v_s1 && better) begin
						lowest_q <= e_key;
						pick_q   <= idx_s1;
						found_q  <= 1'b1;
					end
					if (drained) begin
						cnt_q <= '0;
						if ((state_q == ST_SCAN) && found_q) begin
							state_q <= ST_RELAX;
						end else begin
							// End of one tree step
							left_q   <= left_q - NW'(1);
							lowest_q <= KEY_INF;
							found_q  <= 1'b0;
							if (left_q == NW'(1)) begin
								oi_q    <= VB'(1);
								total_q <= '0;
								state_q <= ST_ORDV;
							end else begin
								state_q <= ST_SCAN;
							end
						end
					end
				end
				ST_ORDV: begin
					state_q <= ST_ORDA;
				end
				ST_ORDA: begin
					oreach_q <= !e_key[WEIGHT_BITS];
					opar_q   <= e_par;
					state_q  <= ST_OEMIT;
				end
				ST_OEMIT: begin
					if (load) begin
						total_q <= total_q + TW'(ew_add);
						if (is_last) begin
							state_q <= ST_IDLE;
						end else begin
							oi_q    <= oi_q + VB'(1);
							state_q <= ST_ORDV;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q.vertex        <= IDX_W'(oi_q);
			res_q.parent_vertex <= oreach_q ? IDX_W'(opar_q) : '0;
			res_q.edge_weight   <= WGT_W'(ew_add);
			res_q.reachable     <= oreach_q;
			res_q.total_cost    <= TOTAL_W'(total_q + TW'(ew_add));
			res_q.last          <= is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = res_q;

endmodule
